>>> hdl/peer_address_record_filter_defines.svh
// Assertion helpers for the peer address record filter.
`ifndef PEER_ADDRESS_RECORD_FILTER_DEFINES_SVH
`define PEER_ADDRESS_RECORD_FILTER_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define APR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication checked outside reset.
`define APR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/apr_pkg.sv
package apr_pkg;

  // Default depth of the seen table.
  localparam int unsigned TABLE_DEPTH_DEF = 4096;

  // Width of the result total field.
  localparam int unsigned TOTAL_W = 13;

  // Record judgment request from the parser to the seen-table unit.
  typedef struct packed {
    logic        req;
    logic [31:0] ip;
    logic [15:0] port;
  } judge_t;

  // True when the address is outside the zero, loopback, private and link-local ranges.
  function automatic logic is_public(input logic [31:0] ip);
    logic [7:0] a0;
    logic [7:0] a1;
    a0 = ip[31:24];
    a1 = ip[23:16];
    is_public = 1'b1;
    if (a0 == 8'd0 || a0 == 8'd127 || a0 == 8'd10) is_public = 1'b0;
    if (a0 == 8'd192 && a1 == 8'd168) is_public = 1'b0;
    if (a0 == 8'd172 && a1 >= 8'd16 && a1 <= 8'd31) is_public = 1'b0;
    if (a0 == 8'd169 && a1 == 8'd254) is_public = 1'b0;
  endfunction

endpackage

>>> hdl/apr_parse.sv
module apr_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      msg_byte,
  input  logic            command,
  input  logic            first_byte,
  input  logic            last_byte,
  output apr_pkg::judge_t judge
);
  import apr_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_DONE, PH_V1REC, PH_TIME, PH_SVC, PH_NET, PH_NET16,
    PH_NETSKIP, PH_LEN, PH_LEN16, PH_LENSKIP, PH_ADDR, PH_PORT
  } phase_t;

  localparam logic [7:0] CS_16  = 8'hfd;
  localparam logic [7:0] CS_32  = 8'hfe;
  localparam logic [7:0] CS_64  = 8'hff;

  phase_t      ph_r, ph_nxt;
  logic [7:0]  rl_r, rl_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic [15:0] net_r, net_nxt;
  logic [15:0] alen_r, alen_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] port_r, port_nxt;

  // Next parse state and a judgment request for the current byte.
  always_comb begin
    ph_nxt = ph_r;
    rl_nxt = rl_r;
    fc_nxt = fc_r;
    net_nxt = net_r;
    alen_nxt = alen_r;
    addr_nxt = addr_r;
    port_nxt = port_r;
    judge.req = 1'b0;
    judge.ip = addr_r;
    judge.port = port_r;
    if (first_byte) begin
      fc_nxt = '0; net_nxt = '0; alen_nxt = '0; addr_nxt = '0; port_nxt = '0;
      rl_nxt = msg_byte;
      if (msg_byte == 8'd0) ph_nxt = PH_DONE;
      else ph_nxt = command ? PH_TIME : PH_V1REC;
    end else begin
      case (ph_r)
        PH_V1REC: begin
          if (fc_r >= 16'd12 && fc_r <= 16'd15)
            addr_nxt = addr_r | (32'(msg_byte) << (5'd24 - {fc_r[1:0], 3'b000}));
          else if (fc_r >= 16'd28)
            port_nxt = {port_r[7:0], msg_byte};
          fc_nxt = fc_r + 16'd1;
          if (fc_nxt >= 16'd30) begin
            judge.req = 1'b1;
            judge.ip = addr_nxt;
            judge.port = port_nxt;
            fc_nxt = '0; net_nxt = '0; alen_nxt = '0; addr_nxt = '0; port_nxt = '0;
            rl_nxt = rl_r - 8'd1;
            ph_nxt = (rl_nxt == 8'd0) ? PH_DONE : PH_V1REC;
          end
        end
        PH_TIME: begin
          fc_nxt = fc_r + 16'd1;
          if (fc_nxt >= 16'd4) begin
            fc_nxt = '0;
            ph_nxt = PH_SVC;
          end
        end
        PH_SVC: begin
          if (!msg_byte[7]) ph_nxt = PH_NET;
        end
        PH_NET: begin
          fc_nxt = '0;
          if (msg_byte < CS_16) begin
            net_nxt = {8'd0, msg_byte};
            ph_nxt = PH_LEN;
          end else if (msg_byte == CS_16) begin
            ph_nxt = PH_NET16;
          end else begin
            fc_nxt = (msg_byte == CS_32) ? 16'd4 : 16'd8;
            ph_nxt = PH_NETSKIP;
          end
        end
        PH_NET16: begin
          net_nxt = net_r | (fc_r[0] ? {msg_byte, 8'd0} : {8'd0, msg_byte});
          fc_nxt = fc_r + 16'd1;
          if (fc_nxt >= 16'd2) begin
            fc_nxt = '0;
            ph_nxt = PH_LEN;
          end
        end
        PH_NETSKIP: begin
          fc_nxt = fc_r - 16'd1;
          if (fc_nxt == 16'd0) ph_nxt = PH_LEN;
        end
        PH_LEN: begin
          fc_nxt = '0;
          if (msg_byte < CS_16) begin
            alen_nxt = {8'd0, msg_byte};
            ph_nxt = (alen_nxt == 16'd0) ? PH_PORT : PH_ADDR;
          end else if (msg_byte == CS_16) begin
            ph_nxt = PH_LEN16;
          end else if (msg_byte == CS_32) begin
            fc_nxt = 16'd4;
            ph_nxt = PH_LENSKIP;
          end else begin
            // A length of CS_64 is malformed and ends the message.
            ph_nxt = (msg_byte == CS_64) ? PH_DONE : PH_DONE;
          end
        end
        PH_LEN16: begin
          alen_nxt = alen_r | (fc_r[0] ? {msg_byte, 8'd0} : {8'd0, msg_byte});
          fc_nxt = fc_r + 16'd1;
          if (fc_nxt >= 16'd2) begin
            fc_nxt = '0;
            ph_nxt = (alen_nxt == 16'd0) ? PH_PORT : PH_ADDR;
          end
        end
        PH_LENSKIP: begin
          fc_nxt = fc_r - 16'd1;
          if (fc_nxt == 16'd0) ph_nxt = (alen_r == 16'd0) ? PH_PORT : PH_ADDR;
        end
        PH_ADDR: begin
          if (fc_r < 16'd4)
            addr_nxt = addr_r | (32'(msg_byte) << (5'd24 - {fc_r[1:0], 3'b000}));
          fc_nxt = fc_r + 16'd1;
          if (fc_nxt >= alen_r) begin
            fc_nxt = '0;
            ph_nxt = PH_PORT;
          end
        end
        PH_PORT: begin
          port_nxt = {port_r[7:0], msg_byte};
          fc_nxt = fc_r + 16'd1;
          if (fc_nxt >= 16'd2) begin
            if (net_r == 16'd1 && alen_r == 16'd4) begin
              judge.req = 1'b1;
              judge.ip = addr_r;
              judge.port = port_nxt;
            end
            fc_nxt = '0; net_nxt = '0; alen_nxt = '0; addr_nxt = '0; port_nxt = '0;
            rl_nxt = rl_r - 8'd1;
            ph_nxt = (rl_nxt == 8'd0) ? PH_DONE : PH_TIME;
          end
        end
        default: begin
        end
      endcase
    end
    // End of message: a truncated IPv4 v2 record is judged with port zero.
    if (last_byte) begin
      if ((ph_nxt == PH_ADDR || ph_nxt == PH_PORT) && net_nxt == 16'd1 &&
          alen_nxt == 16'd4) begin
        judge.req = 1'b1;
        judge.ip = addr_nxt;
        judge.port = 16'd0;
      end
      fc_nxt = '0; net_nxt = '0; alen_nxt = '0; addr_nxt = '0; port_nxt = '0;
      rl_nxt = '0;
      ph_nxt = PH_IDLE;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      rl_r <= '0;
      fc_r <= '0;
      net_r <= '0;
      alen_r <= '0;
      addr_r <= '0;
      port_r <= '0;
    end else if (step) begin
      ph_r <= ph_nxt;
      rl_r <= rl_nxt;
      fc_r <= fc_nxt;
      net_r <= net_nxt;
      alen_r <= alen_nxt;
      addr_r <= addr_nxt;
      port_r <= port_nxt;
    end
  end

endmodule

>>> hdl/peer_address_record_filter.sv
// A public record is searched against the stored endpoints one entry at a time
// through the single table read port (read step, then compare step); a match
// ends the search with no result, else the result is registered at the emit
// step, later while the previous result is still waiting in the output register.
// Throughput: one byte per cycle outside searches; the input stalls during a
// search and while a new result waits for the output register.
// Reset: synchronous, active low; parser goes idle and the stored count goes
// to zero, the table itself is not cleared and needs no clearing pass.
module peer_address_record_filter #(
  parameter int unsigned TABLE_DEPTH = apr_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_command,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_endpoint_ip,
  output logic [15:0] out_endpoint_port,
  output logic        out_stored_flag,
  output logic [apr_pkg::TOTAL_W-1:0] out_stored_total
);
  import apr_pkg::*;
  `include "peer_address_record_filter_defines.svh"

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CMP, ST_EMIT} state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   idx_r;
  logic [47:0]     key_r;
  logic [47:0]     rd_r;
  logic            out_valid_r;
  logic [31:0]     out_ip_r;
  logic [15:0]     out_port_r;
  logic            out_flag_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic [47:0]     mem [TABLE_DEPTH];
  logic            in_acc;
  logic            out_free;
  logic            do_write;
  judge_t          judge;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign do_write = (state_r == ST_EMIT) && out_free && (cnt_r < CW'(TABLE_DEPTH));

  apr_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .msg_byte   (in_msg_byte),
    .command    (in_command),
    .first_byte (in_first_byte),
    .last_byte  (in_last_byte),
    .judge      (judge)
  );

  // Seen table: one write port for inserts, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (do_write) mem[cnt_r[AW-1:0]] <= key_r;
    rd_r <= mem[idx_r];
  end

  // Search sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register fills at the emit step and drains when accepted.
      if (state_r == ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc && judge.req && is_public(judge.ip)) begin
            key_r <= {judge.ip, judge.port};
            idx_r <= '0;
            state_r <= (cnt_r == '0) ? ST_EMIT : ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (rd_r == key_r) begin
            state_r <= ST_IDLE;
          end else if (CW'(idx_r) + CW'(1) == cnt_r) begin
            state_r <= ST_EMIT;
          end else begin
            idx_r <= AW'(idx_r + AW'(1));
            state_r <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_ip_r <= key_r[47:16];
            out_port_r <= key_r[15:0];
            out_flag_r <= do_write;
            out_total_r <= TOTAL_W'(do_write ? cnt_r + CW'(1) : cnt_r);
            if (do_write) cnt_r <= cnt_r + CW'(1);
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_endpoint_ip = out_ip_r;
  assign out_endpoint_port = out_port_r;
  assign out_stored_flag = out_flag_r;
  assign out_stored_total = out_total_r;

  // A new result only comes from the emit step.
  `APR_ASSERT_IMPL(a_emit_src, $rose(out_valid), $past(state_r == ST_EMIT))
  // The stored count never passes the table depth.
  `APR_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_r <= CW'(TABLE_DEPTH))
  // The stored count grows by one only with an insert.
  `APR_ASSERT_NEXT(a_cnt_step, !do_write, $stable(cnt_r))

endmodule

>>> dv/tb.sv
// Expected endpoint computed by the parser model.
typedef struct {
  logic [31:0] ip;
  logic [15:0] port;
  logic        flag;
  logic [12:0] total;
} endpoint_t;

class endpoint_scoreboard;
  typedef enum logic [3:0] {
    P_IDLE, P_DONE, P_V1REC, P_TIME, P_SVC, P_NET, P_NET16, P_NETSKIP,
    P_LEN, P_LEN16, P_LENSKIP, P_ADDR, P_PORT
  } phase_t;

  int unsigned depth;
  phase_t      phase;
  logic [7:0]  recs_left;
  logic [15:0] fcnt;
  logic [15:0] net_id;
  logic [15:0] addr_len;
  logic [31:0] addr;
  logic [15:0] port;
  logic [47:0] seen[$];
  endpoint_t   pending_q[$];
  int          errors;

  function new(int unsigned d);
    depth = d;
    phase = P_IDLE;
    recs_left = '0;
    errors = 0;
    clear_rec();
  endfunction

  function void clear_rec();
    fcnt = '0;
    net_id = '0;
    addr_len = '0;
    addr = '0;
    port = '0;
  endfunction

  // Public unless zero, loopback, 10/8, 192.168/16, 172.16/12 or 169.254/16.
  function bit routable(logic [31:0] ip);
    logic [7:0] o0;
    logic [7:0] o1;
    o0 = ip[31:24];
    o1 = ip[23:16];
    if (o0 == 0 || o0 == 127 || o0 == 10) return 0;
    if (o0 == 192 && o1 == 168) return 0;
    if (o0 == 172 && o1 >= 16 && o1 <= 31) return 0;
    if (o0 == 169 && o1 == 254) return 0;
    return 1;
  endfunction

  // Decide whether an endpoint is new; queue the expected result if so.
  function bit judge_endpoint(logic [31:0] ip, logic [15:0] p);
    logic [47:0] key;
    endpoint_t e;
    key = {ip, p};
    if (!routable(ip)) return 0;
    foreach (seen[i]) if (seen[i] == key) return 0;
    e.flag = 0;
    if (seen.size() < depth) begin
      seen.push_back(key);
      e.flag = 1;
    end
    e.ip = ip;
    e.port = p;
    e.total = 13'(seen.size());
    pending_q.push_back(e);
    return 1;
  endfunction

  function void finish_rec(phase_t nxt);
    clear_rec();
    recs_left = recs_left - 8'd1;
    phase = (recs_left == 0) ? P_DONE : nxt;
  endfunction

  function void enter_addr();
    fcnt = '0;
    phase = (addr_len == 0) ? P_PORT : P_ADDR;
  endfunction

  // Advance the parser by one accepted request.
  function void note_request(logic [7:0] b, logic cmd, logic first, logic last);
    bit hit;
    hit = 0;
    if (first) begin
      clear_rec();
      recs_left = b;
      phase = (b == 0) ? P_DONE : (cmd ? P_TIME : P_V1REC);
    end else begin
      case (phase)
        P_V1REC: begin
          if (fcnt >= 12 && fcnt <= 15) addr |= 32'(b) << (24 - 8 * (fcnt - 12));
          else if (fcnt >= 28) port = {port[7:0], b};
          fcnt++;
          if (fcnt >= 30) begin
            hit = judge_endpoint(addr, port);
            finish_rec(P_V1REC);
          end
        end
        P_TIME: begin
          fcnt++;
          if (fcnt >= 4) begin
            fcnt = '0;
            phase = P_SVC;
          end
        end
        P_SVC: if (!b[7]) phase = P_NET;
        P_NET: begin
          fcnt = '0;
          if (b < 8'hfd) begin
            net_id = 16'(b);
            phase = P_LEN;
          end else if (b == 8'hfd) phase = P_NET16;
          else begin
            fcnt = (b == 8'hfe) ? 16'd4 : 16'd8;
            phase = P_NETSKIP;
          end
        end
        P_NET16: begin
          net_id |= 16'(b) << (8 * fcnt[0]);
          fcnt++;
          if (fcnt >= 2) begin
            fcnt = '0;
            phase = P_LEN;
          end
        end
        P_NETSKIP: begin
          fcnt--;
          if (fcnt == 0) phase = P_LEN;
        end
        P_LEN: begin
          fcnt = '0;
          if (b < 8'hfd) begin
            addr_len = 16'(b);
            enter_addr();
          end else if (b == 8'hfd) phase = P_LEN16;
          else if (b == 8'hfe) begin
            fcnt = 16'd4;
            phase = P_LENSKIP;
          end else phase = P_DONE;
        end
        P_LEN16: begin
          addr_len |= 16'(b) << (8 * fcnt[0]);
          fcnt++;
          if (fcnt >= 2) enter_addr();
        end
        P_LENSKIP: begin
          fcnt--;
          if (fcnt == 0) enter_addr();
        end
        P_ADDR: begin
          if (fcnt < 4) addr |= 32'(b) << (24 - 8 * fcnt);
          fcnt++;
          if (fcnt >= addr_len) begin
            fcnt = '0;
            phase = P_PORT;
          end
        end
        P_PORT: begin
          port = {port[7:0], b};
          fcnt++;
          if (fcnt >= 2) begin
            if (net_id == 1 && addr_len == 4) hit = judge_endpoint(addr, port);
            finish_rec(P_TIME);
          end
        end
        default: ;
      endcase
    end
    // A v2 IPv4 record cut short by the message end is judged with port 0.
    if (last) begin
      if (!hit && (phase == P_ADDR || phase == P_PORT) && net_id == 1 && addr_len == 4)
        hit = judge_endpoint(addr, 16'd0);
      clear_rec();
      recs_left = '0;
      phase = P_IDLE;
    end
  endfunction

  // Compare one accepted result with the oldest expected endpoint.
  function void check_result(logic [31:0] ip, logic [15:0] p, logic flag, logic [12:0] total);
    endpoint_t e;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result ip=%h port=%h", $time, ip, p);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (ip !== e.ip) begin
      $display("%0t: ip expected %h actual %h", $time, e.ip, ip);
      errors++;
    end
    if (p !== e.port) begin
      $display("%0t: port expected %h actual %h", $time, e.port, p);
      errors++;
    end
    if (flag !== e.flag) begin
      $display("%0t: stored_flag expected %b actual %b", $time, e.flag, flag);
      errors++;
    end
    if (total !== e.total) begin
      $display("%0t: stored_total expected %0d actual %0d", $time, e.total, total);
      errors++;
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A small table so that the full-table case is reached.
  localparam int unsigned SEEN_DEPTH = 64;
  localparam int unsigned BYTE_TARGET = 1550;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_msg_byte;
  logic        in_command;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_endpoint_ip;
  logic [15:0] out_endpoint_port;
  logic        out_stored_flag;
  logic [apr_pkg::TOTAL_W-1:0] out_stored_total;

  endpoint_scoreboard sb;
  logic [7:0] msg_q[$];
  int unsigned bytes_sent;
  bit in_burst;
  bit out_burst;

  peer_address_record_filter #(.TABLE_DEPTH(SEEN_DEPTH)) DUT (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

  // Idle length per request; bursts of back-to-back traffic come and go.
  function automatic int unsigned draw_gap(ref bit burst);
    if ($urandom_range(0, 19) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  // Present one byte and hold it until the block accepts it.
  task automatic send_byte(logic [7:0] b, logic cmd, logic first, logic last);
    int unsigned gap;
    gap = draw_gap(in_burst);
    repeat (gap) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_msg_byte = b;
    in_command = cmd;
    in_first_byte = first;
    in_last_byte = last;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note_request(b, cmd, first, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the assembled message; with_last=0 leaves it open.
  task automatic send_msg(logic cmd, bit with_last);
    foreach (msg_q[i])
      send_byte(msg_q[i], cmd, i == 0, with_last && i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  function automatic logic [31:0] pick_ip();
    logic [31:0] pool[10] = '{32'h01020304, 32'h08080808, 32'h0a000001, 32'h7f000001,
                              32'hc0a80101, 32'hac1f0001, 32'ha9fe0101, 32'h00000000,
                              32'hac200001, 32'hac0f0001};
    if ($urandom_range(0, 9) < 4) return pool[$urandom_range(0, 9)];
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 5))
      0: return 16'd8333;
      1: return 16'h0000;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_legacy_record(logic [31:0] ip, logic [15:0] p);
    for (int i = 0; i < 30; i++) begin
      if (i >= 12 && i <= 15) msg_q.push_back(ip[31 - 8 * (i - 12) -: 8]);
      else if (i == 28) msg_q.push_back(p[15:8]);
      else if (i == 29) msg_q.push_back(p[7:0]);
      else msg_q.push_back(8'($urandom));
    end
  endfunction

  // A v2 record; net_kind and len_kind pick how the compact sizes are coded.
  function automatic void push_v2_record(int net_kind, int len_kind,
                                         logic [31:0] ip, logic [15:0] p);
    int n;
    int alen;
    n = $urandom_range(0, 2);
    repeat (4) msg_q.push_back(8'($urandom));
    repeat (n) msg_q.push_back(8'h80 | 8'($urandom));
    msg_q.push_back(8'($urandom_range(0, 127)));
    case (net_kind)
      7: begin msg_q.push_back(8'hfd); msg_q.push_back(8'h01); msg_q.push_back(8'h00); end
      8: begin msg_q.push_back(8'hfe); repeat (4) msg_q.push_back(8'($urandom)); end
      9: begin msg_q.push_back(8'hff); repeat (8) msg_q.push_back(8'($urandom)); end
      10: msg_q.push_back(8'($urandom_range(0, 252)));
      default: msg_q.push_back(8'h01);
    endcase
    alen = 4;
    case (len_kind)
      7: begin msg_q.push_back(8'hfd); msg_q.push_back(8'h04); msg_q.push_back(8'h00); end
      8: begin
        msg_q.push_back(8'hfe);
        repeat (4) msg_q.push_back(8'($urandom));
        alen = 0;
      end
      9: begin alen = $urandom_range(0, 20); msg_q.push_back(8'(alen)); end
      10: begin msg_q.push_back(8'hff); alen = -1; end
      default: msg_q.push_back(8'h04);
    endcase
    if (alen < 0) return;
    for (int i = 0; i < alen; i++)
      msg_q.push_back(i < 4 ? ip[31 - 8 * i -: 8] : 8'($urandom));
    msg_q.push_back(p[15:8]);
    msg_q.push_back(p[7:0]);
  endfunction

  // Mostly well-formed messages with random content, some cut or broken.
  task automatic random_message();
    logic cmd;
    int recs;
    int cut;
    cmd = 1'($urandom_range(0, 1));
    recs = $urandom_range(1, cmd ? 5 : 3);
    msg_q.push_back(8'(recs));
    if ($urandom_range(0, 9) == 0) msg_q[0] = $urandom_range(0, 9) < 3 ? 8'h00 : 8'($urandom);
    for (int r = 0; r < recs; r++) begin
      if (cmd) begin
        if ($urandom_range(0, 3) == 0)
          push_v2_record($urandom_range(0, 10), $urandom_range(0, 10), pick_ip(), pick_port());
        else
          push_v2_record(0, 0, pick_ip(), pick_port());
      end else begin
        push_legacy_record(pick_ip(), pick_port());
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
    if ($urandom_range(0, 7) == 0) msg_q.push_back(8'($urandom));
    send_msg(cmd, $urandom_range(0, 9) != 0);
    // A stray byte after the message.
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'($urandom), 0, 1'($urandom));
  endtask

  // Result side: random stall per result, checked at the accepting edge.
  initial begin
    int unsigned gap;
    out_stall = 1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap(out_burst);
      if (gap != 0) begin
        out_stall = 1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_endpoint_ip, out_endpoint_port, out_stored_flag, out_stored_total);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned drain;
    sb = new(SEEN_DEPTH);
    bytes_sent = 0;
    in_burst = 0;
    out_burst = 0;
    rst_n = 0;
    in_valid = 0;
    in_msg_byte = '0;
    in_command = 0;
    in_first_byte = 0;
    in_last_byte = 0;
    repeat (5) @(negedge clk);
    rst_n = 1;

    // Directed: a stray byte, an empty message, a full v2 record, a v2 cut short.
    send_byte(8'hff, 1, 0, 0);
    send_byte(8'h00, 0, 1, 0);
    send_byte(8'h55, 0, 0, 1);
    msg_q.push_back(8'h01);
    push_v2_record(0, 0, 32'hffffffff, 16'hffff);
    send_msg(1, 1);
    msg_q.push_back(8'h01);
    push_v2_record(0, 0, 32'h01020304, 16'h208d);
    repeat (3) void'(msg_q.pop_back());
    send_msg(1, 1);

    while (bytes_sent < BYTE_TARGET) random_message();
    in_valid = 0;

    drain = 0;
    while (sb.pending_q.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (2 * SEEN_DEPTH + 50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
